// File: rtl/core/crc16_frame_deframer_core_defines.svh
// Assertion macros shared by the frame deframer RTL.
// Standalone header; included by crcfd_parser, the module that carries assertions.
`ifndef CRC16_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define CRC16_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CRCFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CRCFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CRCFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CRCFD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/crcfd_pkg.sv
// Shared types and constants of the CRC-16 frame deframer.
// No dependencies.
package crcfd_pkg;

    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CfgStartFlag   = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgMinFrameLen = 1'b1;

    localparam logic [7:0] StartFlagReset   = 8'h68;
    localparam logic [7:0] MinFrameLenReset = 8'd8;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusCrcError = 2'd1;
    localparam logic [1:0] StatusTooShort = 2'd2;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [7:0] HeaderLen = 8'd4;

    typedef struct packed {
        logic [7:0] sof_byte;
        logic [7:0] min_frame_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [15:0] sequence_number;
        logic [7:0]  crypt_mode;
        logic [7:0]  msg_kind;
        logic [7:0]  body_length;
        logic [1:0]  status;
        logic        last;
    } result_t;

endpackage

// File: rtl/core/crc16_frame_deframer_core.sv
// Top level of the CRC-16 checked frame deframer: configuration registers and wiring.
// Depends on crcfd_pkg, crcfd_parser and crcfd_out_reg.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_valid / s_ready     s_rx_byte
//   m_        out        m_valid / m_ready     payload, header, status and last fields
//   cfg_      in         cfg_wr_en             cfg_index, cfg_wdata
//
// Each received byte passes through the input register and then the result
// register, so a result appears only after both registers.
// Unless the result channel stalls, one byte is taken per cycle in one parser pass.
// Synchronous active-low reset returns the parser to hunting for the start flag.
// A stalled result channel holds the result register, then the input register.
module crc16_frame_deframer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [crcfd_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_payload_byte,
    output logic [7:0]                    m_payload_index,
    output logic [15:0]                   m_sequence_number,
    output logic [7:0]                    m_crypt_mode,
    output logic [7:0]                    m_msg_kind,
    output logic [7:0]                    m_body_length,
    output logic [1:0]                    m_status,
    output logic                          m_last
);

    crcfd_pkg::cfg_t    cfg_reg;
    crcfd_pkg::result_t res;
    crcfd_pkg::result_t out_data;
    logic               res_valid;
    logic               out_can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sof_byte         <= crcfd_pkg::StartFlagReset;
            cfg_reg.min_frame_length <= crcfd_pkg::MinFrameLenReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                crcfd_pkg::CfgStartFlag:   cfg_reg.sof_byte         <= cfg_wdata;
                crcfd_pkg::CfgMinFrameLen: cfg_reg.min_frame_length <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    crcfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_byte   (s_rx_byte),
        .out_ready (out_can_load),
        .res_valid (res_valid),
        .res       (res)
    );

    crcfd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .can_load  (out_can_load),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_payload_byte    = out_data.payload_byte;
    assign m_payload_index   = out_data.payload_index;
    assign m_sequence_number = out_data.sequence_number;
    assign m_crypt_mode      = out_data.crypt_mode;
    assign m_msg_kind        = out_data.msg_kind;
    assign m_body_length     = out_data.body_length;
    assign m_status          = out_data.status;
    assign m_last            = out_data.last;

endmodule

// File: rtl/core/crcfd_crc_step.sv
// One byte update of the reflected CRC-16/MODBUS register.
// Depends on crcfd_pkg for the polynomial.
module crcfd_crc_step (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb begin
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ crcfd_pkg::CrcPoly;
            end else begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule

// File: rtl/core/crcfd_parser.sv
// Input register, frame phase sequencer and header holding registers.
// Depends on crcfd_pkg, crcfd_crc_step and the assertion macro header.
`include "crc16_frame_deframer_core_defines.svh"

module crcfd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  crcfd_pkg::cfg_t    cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               out_ready,
    output logic               res_valid,
    output crcfd_pkg::result_t res
);

    typedef enum logic [8:0] {
        PH_HUNT  = 9'b000000001,
        PH_LEN   = 9'b000000010,
        PH_SEQLO = 9'b000000100,
        PH_SEQHI = 9'b000001000,
        PH_ENC   = 9'b000010000,
        PH_TYPE  = 9'b000100000,
        PH_PAY   = 9'b001000000,
        PH_CRCLO = 9'b010000000,
        PH_CRCHI = 9'b100000000
    } phase_t;

    logic        byte_vld_reg;
    logic [7:0]  byte_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] seq_reg, seq_next;
    logic [7:0]  enc_reg, enc_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  fcrc_reg, fcrc_next;
    logic [15:0] crc_upd;
    logic        fire;
    logic        too_short;

    crcfd_crc_step u_crc (
        .crc_in  (crc_reg),
        .data_in (byte_reg),
        .crc_out (crc_upd)
    );

    assign fire     = byte_vld_reg && out_ready;
    assign in_ready = !byte_vld_reg || out_ready;

    assign too_short = (byte_reg < crcfd_pkg::HeaderLen) ||
        (({1'b0, byte_reg} + {1'b0, crcfd_pkg::HeaderLen}) < {1'b0, cfg.min_frame_length});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_vld_reg <= 1'b0;
        end else if (in_ready) begin
            byte_vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            byte_reg <= in_byte;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        seq_next   = seq_reg;
        enc_next   = enc_reg;
        type_next  = type_reg;
        fcrc_next  = fcrc_reg;
        res_valid  = 1'b0;
        res.payload_byte    = 8'h00;
        res.payload_index   = 8'h00;
        res.sequence_number = seq_reg;
        res.crypt_mode      = enc_reg;
        res.msg_kind        = type_reg;
        res.body_length     = len_reg;
        res.status          = crcfd_pkg::StatusOk;
        res.last            = 1'b0;
        if (fire) begin
            unique case (phase_reg)
                PH_LEN: begin
                    len_next = byte_reg;
                    if (too_short) begin
                        res_valid           = 1'b1;
                        res.sequence_number = 16'h0000;
                        res.crypt_mode      = 8'h00;
                        res.msg_kind        = 8'h00;
                        res.body_length     = byte_reg;
                        res.status          = crcfd_pkg::StatusTooShort;
                        res.last            = 1'b1;
                        phase_next          = PH_HUNT;
                    end else begin
                        crc_next   = crcfd_pkg::CrcInit;
                        cnt_next   = 8'h00;
                        phase_next = PH_SEQLO;
                    end
                end
                PH_SEQLO: begin
                    crc_next   = crc_upd;
                    seq_next   = {8'h00, byte_reg};
                    phase_next = PH_SEQHI;
                end
                PH_SEQHI: begin
                    crc_next   = crc_upd;
                    seq_next   = {byte_reg, seq_reg[7:0]};
                    phase_next = PH_ENC;
                end
                PH_ENC: begin
                    crc_next   = crc_upd;
                    enc_next   = byte_reg;
                    phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    crc_next   = crc_upd;
                    type_next  = byte_reg;
                    cnt_next   = 8'h00;
                    phase_next = (len_reg > crcfd_pkg::HeaderLen) ? PH_PAY : PH_CRCLO;
                end
                PH_PAY: begin
                    crc_next = crc_upd;
                    cnt_next = cnt_reg + 8'd1;
                    if (({1'b0, cnt_reg} + 9'd1 + {1'b0, crcfd_pkg::HeaderLen})
                            >= {1'b0, len_reg}) begin
                        phase_next = PH_CRCLO;
                    end
                    res_valid         = 1'b1;
                    res.payload_byte  = byte_reg;
                    res.payload_index = cnt_reg;
                end
                PH_CRCLO: begin
                    fcrc_next  = byte_reg;
                    phase_next = PH_CRCHI;
                end
                PH_CRCHI: begin
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    if (fcrc_reg == crc_reg[7:0] && byte_reg == crc_reg[15:8]) begin
                        res.status = crcfd_pkg::StatusOk;
                    end else begin
                        res.status = crcfd_pkg::StatusCrcError;
                    end
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = (byte_reg == cfg.sof_byte) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
        cnt_reg  <= cnt_next;
        len_reg  <= len_next;
        crc_reg  <= crc_next;
        seq_reg  <= seq_next;
        enc_reg  <= enc_next;
        type_reg <= type_next;
        fcrc_reg <= fcrc_next;
    end

    `CRCFD_ASSERT_IMP(a_pay_index_in_frame, aclk, aresetn,
        res_valid && !res.last,
        ({1'b0, res.payload_index} + 9'd4) < {1'b0, res.body_length})
    `CRCFD_ASSERT_NXT(a_end_returns_to_hunt, aclk, aresetn,
        res_valid && res.last, phase_reg == PH_HUNT)
    `CRCFD_ASSERT_IMP(a_result_needs_room, aclk, aresetn,
        res_valid, out_ready && byte_vld_reg)

endmodule

// File: rtl/core/crcfd_out_reg.sv
// Result register that decouples the parser from the result channel.
// Depends on crcfd_pkg for the result type.
module crcfd_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  crcfd_pkg::result_t load_data,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output crcfd_pkg::result_t out_data
);

    logic               vld_reg;
    crcfd_pkg::result_t data_reg;

    assign can_load  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (load) begin
            vld_reg <= 1'b1;
        end else if (out_ready) begin
            vld_reg <= 1'b0;
        end
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule
